FILE: rtl/csv_field_tokenizer_top_defines.svh
`ifndef CSV_FIELD_TOKENIZER_TOP_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_TOP_DEFINES_SVH

// property holds on every clock edge outside reset
`define CFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression never true outside reset
`define CFT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/cft_pkg.sv
package cft_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam int RESULT_LIMIT = 35;
  localparam int CMP_W        = 7;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOL  = 1'b1;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_FEND = 2'd1;
  localparam logic [1:0] KIND_LEND = 2'd2;

  localparam logic [2:0] LS_OK       = 3'd0;
  localparam logic [2:0] LS_QUOTE    = 3'd1;
  localparam logic [2:0] LS_ESCAPE   = 3'd2;
  localparam logic [2:0] LS_EMPTY    = 3'd3;
  localparam logic [2:0] LS_TOO_MANY = 3'd4;
  localparam logic [2:0] LS_OVERFLOW = 3'd5;

  localparam logic REG_DELIM = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_BYTE,
    ST_LEND
  } cft_state_t;

  typedef struct packed {
    logic out_free;
    logic flush_start;
    logic lend_start;
    logic flush_last;
    logic flush_drop;
  } cft_status_t;

  typedef struct packed {
    logic accept;
    logic emit_blank;
    logic emit_byte;
    logic emit_lend;
  } cft_cmd_t;

endpackage

FILE: rtl/cft_ctrl.sv
`include "csv_field_tokenizer_top_defines.svh"

module cft_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cft_pkg::cft_status_t status,
  output logic                 in_stall,
  output cft_pkg::cft_cmd_t    cmd
);
  import cft_pkg::*;

  cft_state_t state_r;
  cft_state_t state_nxt;
  logic [3:0] cmd_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && status.out_free) begin
          if (status.flush_start) begin
            state_nxt = ST_FLUSH;
          end else if (status.lend_start) begin
            state_nxt = ST_LEND;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free && status.flush_last) begin
          state_nxt = status.flush_drop ? ST_IDLE : ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LEND: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = !status.out_free;
        cmd.accept = in_valid && status.out_free;
      end
      ST_FLUSH: cmd.emit_blank = status.out_free;
      ST_BYTE:  cmd.emit_byte  = status.out_free;
      ST_LEND:  cmd.emit_lend  = status.out_free;
    endcase
  end

  assign cmd_vec = {cmd.accept, cmd.emit_blank, cmd.emit_byte, cmd.emit_lend};

  `CFT_ASSERT(a_cmd_onehot, $onehot0(cmd_vec), "more than one datapath command")
  `CFT_ASSERT(a_byte_after_flush,
    (state_r == ST_BYTE) |-> ($past(state_r) == ST_FLUSH || $past(state_r) == ST_BYTE),
    "byte state entered without a flush")
  `CFT_ASSERT(a_lend_after_idle,
    (state_r == ST_LEND) |-> ($past(state_r) == ST_IDLE || $past(state_r) == ST_LEND),
    "line end state entered from a busy state")

endmodule

FILE: rtl/cft_datapath.sv
`include "csv_field_tokenizer_top_defines.svh"

module cft_datapath #(
  parameter int MAX_FIELDS    = 32,
  parameter int PENDING_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_command,
  input  logic [7:0]           in_char_byte,
  input  logic [7:0]           delim,
  input  logic                 out_stall,
  input  cft_pkg::cft_cmd_t    cmd,
  output cft_pkg::cft_status_t status,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_out_byte,
  output logic [4:0]           out_field_index,
  output logic [5:0]           out_field_count,
  output logic [2:0]           out_line_status,
  output logic                 out_last
);
  import cft_pkg::*;

  localparam int FW = $clog2(MAX_FIELDS);
  localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PW = $clog2(PENDING_DEPTH + 1);
  localparam logic [FW-1:0] FIELD_LAST = FW'(MAX_FIELDS - 1);
  localparam logic [31:0]   MAXF_W     = 32'(MAX_FIELDS);

  typedef enum logic [3:0] {
    ACT_EOL,
    ACT_IGNORE,
    ACT_TRACK,
    ACT_ESCAPED,
    ACT_QUOTE,
    ACT_DELIM,
    ACT_BSLASH,
    ACT_SKIP,
    ACT_PLAIN
  } cft_act_t;

  logic          inq_r, inq_nxt;
  logic          esc_r, esc_nxt;
  logic          skip_r, skip_nxt;
  logic          started_r, started_nxt;
  logic          head_r, head_nxt;
  logic [FW-1:0] field_r, field_nxt;
  logic [PW-1:0] pend_cnt_r, pend_cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          many_r, many_nxt;
  logic [IW-1:0] flush_idx_r, flush_idx_nxt;
  logic [7:0]    hold_byte_r, hold_byte_nxt;
  logic [7:0]    rd_data_r;
  logic [7:0]    pend_mem [PENDING_DEPTH];

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic [4:0]    out_index_r, out_index_nxt;
  logic [5:0]    out_count_r, out_count_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  cft_act_t      act;
  logic [7:0]    b;
  logic          is_blank;
  logic          is_sp_tab;
  logic          is_cr_lf;
  logic          out_free;
  logic          pend_room;
  logic          pend_empty;
  logic          do_content;
  logic          do_clear;
  logic          load;
  logic          mem_we;
  logic [IW-1:0] idx_inc;
  logic [31:0]   field_w;
  logic [31:0]   count_w;
  logic [2:0]    lend_status;

  assign b          = in_char_byte;
  assign is_sp_tab  = (b == CH_SPACE) || (b == CH_TAB);
  assign is_cr_lf   = (b == CH_CR) || (b == CH_LF);
  assign is_blank   = is_sp_tab || is_cr_lf;
  assign out_free   = !out_valid_r || !out_stall;
  assign pend_room  = CMP_W'(pend_cnt_r) < CMP_W'(PENDING_DEPTH);
  assign pend_empty = (pend_cnt_r == '0);
  assign field_w    = 32'(field_r);
  assign count_w    = field_w + 32'd1;
  assign idx_inc    = (CMP_W'(flush_idx_r) + CMP_W'(1) == CMP_W'(PENDING_DEPTH)) ?
                      '0 : flush_idx_r + IW'(1);

  always_comb begin
    priority if (in_command == CMD_EOL) begin
      act = ACT_EOL;
    end else if (head_r && (b == CH_CR)) begin
      act = ACT_IGNORE;
    end else if (many_r) begin
      act = ACT_TRACK;
    end else if (esc_r) begin
      act = ACT_ESCAPED;
    end else if (b == CH_QUOTE) begin
      act = ACT_QUOTE;
    end else if (!inq_r && (b == delim)) begin
      act = ACT_DELIM;
    end else if (b == CH_BSLASH) begin
      act = ACT_BSLASH;
    end else if (skip_r && is_sp_tab) begin
      act = ACT_SKIP;
    end else begin
      act = ACT_PLAIN;
    end
  end

  always_comb begin
    priority if (inq_r) begin
      lend_status = LS_QUOTE;
    end else if (esc_r) begin
      lend_status = LS_ESCAPE;
    end else if (many_r) begin
      lend_status = LS_TOO_MANY;
    end else if (ovf_r) begin
      lend_status = LS_OVERFLOW;
    end else begin
      lend_status = LS_OK;
    end
  end

  always_comb begin
    status.out_free    = out_free;
    status.flush_start = ((act == ACT_ESCAPED) || (act == ACT_PLAIN)) &&
                         !is_blank && !pend_empty;
    status.lend_start  = (act == ACT_EOL) && started_r && !many_r;
    status.flush_drop  = CMP_W'(flush_idx_r) == CMP_W'(RESULT_LIMIT - 1);
    status.flush_last  = status.flush_drop ||
                         (CMP_W'(flush_idx_r) + CMP_W'(1) == CMP_W'(pend_cnt_r));
  end

  always_comb begin
    inq_nxt        = inq_r;
    esc_nxt        = esc_r;
    skip_nxt       = skip_r;
    started_nxt    = started_r;
    head_nxt       = head_r;
    field_nxt      = field_r;
    pend_cnt_nxt   = pend_cnt_r;
    ovf_nxt        = ovf_r;
    many_nxt       = many_r;
    flush_idx_nxt  = flush_idx_r;
    hold_byte_nxt  = hold_byte_r;
    do_content     = 1'b0;
    do_clear       = 1'b0;
    load           = 1'b0;
    mem_we         = 1'b0;
    out_kind_nxt   = KIND_BYTE;
    out_byte_nxt   = '0;
    out_index_nxt  = '0;
    out_count_nxt  = '0;
    out_status_nxt = LS_OK;
    out_last_nxt   = 1'b1;

    if (cmd.accept) begin
      flush_idx_nxt = '0;
      if (act != ACT_EOL) begin
        head_nxt = 1'b0;
        if ((act != ACT_IGNORE) && !is_cr_lf) begin
          started_nxt = 1'b1;
        end
      end
      unique case (act)
        ACT_EOL: begin
          load = 1'b1;
          if (!started_r) begin
            out_kind_nxt   = KIND_LEND;
            out_status_nxt = LS_EMPTY;
            do_clear       = 1'b1;
          end else if (many_r) begin
            out_kind_nxt   = KIND_LEND;
            out_count_nxt  = MAXF_W[5:0];
            out_status_nxt = lend_status;
            do_clear       = 1'b1;
          end else begin
            out_kind_nxt  = KIND_FEND;
            out_index_nxt = field_w[4:0];
            out_last_nxt  = 1'b0;
          end
        end
        ACT_IGNORE: begin
        end
        ACT_TRACK: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (b == CH_QUOTE) begin
            inq_nxt = !inq_r;
          end else if (b == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end
        end
        ACT_ESCAPED: begin
          esc_nxt    = 1'b0;
          skip_nxt   = 1'b0;
          do_content = 1'b1;
        end
        ACT_QUOTE: inq_nxt = !inq_r;
        ACT_DELIM: begin
          load          = 1'b1;
          out_kind_nxt  = KIND_FEND;
          out_index_nxt = field_w[4:0];
          started_nxt   = 1'b1;
          pend_cnt_nxt  = '0;
          skip_nxt      = 1'b1;
          if (field_r == FIELD_LAST) begin
            many_nxt = 1'b1;
          end else begin
            field_nxt = field_r + FW'(1);
          end
        end
        ACT_BSLASH: esc_nxt = 1'b1;
        ACT_SKIP: begin
        end
        ACT_PLAIN: begin
          skip_nxt   = 1'b0;
          do_content = 1'b1;
        end
      endcase

      if (do_content) begin
        if (is_blank) begin
          if (pend_room) begin
            mem_we       = 1'b1;
            pend_cnt_nxt = pend_cnt_r + PW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (pend_empty) begin
          load          = 1'b1;
          out_byte_nxt  = b;
          out_index_nxt = field_w[4:0];
        end else begin
          hold_byte_nxt = b;
        end
      end
    end

    if (cmd.emit_blank) begin
      load          = 1'b1;
      out_byte_nxt  = rd_data_r;
      out_index_nxt = field_w[4:0];
      out_last_nxt  = status.flush_drop;
      flush_idx_nxt = idx_inc;
      if (status.flush_drop) begin
        pend_cnt_nxt = '0;
      end
    end

    if (cmd.emit_byte) begin
      load          = 1'b1;
      out_byte_nxt  = hold_byte_r;
      out_index_nxt = field_w[4:0];
      pend_cnt_nxt  = '0;
    end

    if (cmd.emit_lend) begin
      load           = 1'b1;
      out_kind_nxt   = KIND_LEND;
      out_count_nxt  = count_w[5:0];
      out_status_nxt = lend_status;
      do_clear       = 1'b1;
    end

    if (do_clear) begin
      inq_nxt      = 1'b0;
      esc_nxt      = 1'b0;
      skip_nxt     = 1'b1;
      started_nxt  = 1'b0;
      head_nxt     = 1'b1;
      field_nxt    = '0;
      pend_cnt_nxt = '0;
      ovf_nxt      = 1'b0;
      many_nxt     = 1'b0;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r       <= 1'b0;
      esc_r       <= 1'b0;
      skip_r      <= 1'b1;
      started_r   <= 1'b0;
      head_r      <= 1'b1;
      field_r     <= '0;
      pend_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      many_r      <= 1'b0;
      flush_idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      inq_r       <= inq_nxt;
      esc_r       <= esc_nxt;
      skip_r      <= skip_nxt;
      started_r   <= started_nxt;
      head_r      <= head_nxt;
      field_r     <= field_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      ovf_r       <= ovf_nxt;
      many_r      <= many_nxt;
      flush_idx_r <= flush_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_byte_r <= hold_byte_nxt;
    if (load) begin
      out_kind_r   <= out_kind_nxt;
      out_byte_r   <= out_byte_nxt;
      out_index_r  <= out_index_nxt;
      out_count_r  <= out_count_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // pending blank buffer; read port follows the next flush index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pend_mem[pend_cnt_r[IW-1:0]] <= b;
    end
    rd_data_r <= pend_mem[flush_idx_nxt];
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_out_byte    = out_byte_r;
  assign out_field_index = out_index_r;
  assign out_field_count = out_count_r;
  assign out_line_status = out_status_r;
  assign out_last        = out_last_r;

  `CFT_ASSERT(a_pend_bound, (CMP_W'(pend_cnt_r) <= CMP_W'(PENDING_DEPTH)),
    "pending count beyond buffer depth")
  `CFT_ASSERT(a_flush_has_data, (cmd.emit_blank |-> !pend_empty),
    "blank flushed from an empty buffer")
  `CFT_ASSERT_NEVER(a_lend_state, cmd.emit_lend && (many_r || !started_r),
    "two-word line end on a line that needs only one")

endmodule

FILE: rtl/csv_field_tokenizer_top.sv
// A result word is registered on input accept; if pending blanks are flushed first,
// the flush state sends each blank from a registered buffer read.
// Throughput: one input word per cycle in the idle state with the output free; a
// content byte behind pending blanks follows them; a line end closing a field gives
// field and line end words. Input stalls while a result word waits downstream.
// Reset (rst_n low, synchronous): line state cleared, delimiter back to ',', no output.
module csv_field_tokenizer_top #(
  parameter int MAX_FIELDS    = 32,
  parameter int PENDING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_out_byte,
  output logic [4:0]  out_field_index,
  output logic [5:0]  out_field_count,
  output logic [2:0]  out_line_status,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cft_pkg::*;

  logic [7:0]  delim_r;
  logic [7:0]  delim_nxt;
  cft_status_t status;
  cft_cmd_t    cmd;

  assign pready = 1'b1;

  always_comb begin
    delim_nxt = delim_r;
    if (psel && penable && pwrite && (paddr[2] == REG_DELIM)) begin
      delim_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= CH_COMMA;
    end else begin
      delim_r <= delim_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_DELIM) ? {24'd0, delim_r} : '0;

  cft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  cft_datapath #(
    .MAX_FIELDS    (MAX_FIELDS),
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_char_byte    (in_char_byte),
    .delim           (delim_r),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_field_index (out_field_index),
    .out_field_count (out_field_count),
    .out_line_status (out_line_status),
    .out_last        (out_last)
  );

endmodule

FILE: dv/csv_field_tokenizer_top_tb.sv
module csv_field_tokenizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cft_pkg::*;

  localparam int MAX_FIELDS    = 32;
  localparam int PENDING_DEPTH = 32;
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 60;

  typedef struct {
    logic       cmd;
    logic [7:0] ch;
  } line_word_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic [4:0] index;
    logic [5:0] count;
    logic [2:0] status;
    logic       last;
  } token_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_char_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [7:0]  out_out_byte;
  logic [4:0]  out_field_index;
  logic [5:0]  out_field_count;
  logic [2:0]  out_line_status;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  line_word_t pending_words[$];
  token_t     expected_tokens[$];
  token_t     step_tokens[$];
  logic [7:0] blank_q[$];

  logic [7:0] delim;
  logic       tk_in_quotes;
  logic       tk_escape;
  logic       tk_skip_lead;
  logic       tk_started;
  logic       tk_line_head;
  int         tk_field;
  logic       tk_overflow;
  logic       tk_too_many;

  int errors     = 0;
  int words_in   = 0;
  int burst_left = 0;
  int gap_left   = 0;
  int hold_cnt   = 0;
  bit hold_done  = 0;
  int stall_mode = 0;
  int mode_left  = 0;
  int idle_count = 0;

  csv_field_tokenizer_top #(
    .MAX_FIELDS   (MAX_FIELDS),
    .PENDING_DEPTH(PENDING_DEPTH)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_char_byte   (in_char_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_out_byte   (out_out_byte),
    .out_field_index(out_field_index),
    .out_field_count(out_field_count),
    .out_line_status(out_line_status),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 40) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // tokenizer prediction
  function automatic bit is_blank(input logic [7:0] ch);
    return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_LF;
  endfunction

  function automatic void add_token(input logic [1:0] kind, input logic [7:0] data,
                                    input int idx, input int cnt, input logic [2:0] st);
    token_t t;
    t.kind   = kind;
    t.data   = data;
    t.index  = idx[4:0];
    t.count  = cnt[5:0];
    t.status = st;
    t.last   = 1'b0;
    if (step_tokens.size() < RESULT_LIMIT) step_tokens.push_back(t);
  endfunction

  function automatic void put_content(input logic [7:0] ch);
    if (is_blank(ch)) begin
      if (blank_q.size() < PENDING_DEPTH) blank_q.push_back(ch);
      else tk_overflow = 1'b1;
    end else begin
      foreach (blank_q[i]) add_token(KIND_BYTE, blank_q[i], tk_field, 0, LS_OK);
      blank_q.delete();
      add_token(KIND_BYTE, ch, tk_field, 0, LS_OK);
    end
  endfunction

  function automatic void clear_line();
    tk_in_quotes = 1'b0;
    tk_escape    = 1'b0;
    tk_skip_lead = 1'b1;
    tk_started   = 1'b0;
    tk_line_head = 1'b1;
    tk_field     = 0;
    tk_overflow  = 1'b0;
    tk_too_many  = 1'b0;
    blank_q.delete();
  endfunction

  function automatic void tokenize_word(input logic cmd, input logic [7:0] ch);
    logic [2:0] st;
    int         cnt;
    bit         dropped;
    token_t     t;
    dropped = 0;
    if (cmd == CMD_EOL) begin
      if (!tk_started) begin
        add_token(KIND_LEND, 8'h00, 0, 0, LS_EMPTY);
      end else begin
        if (!tk_too_many) add_token(KIND_FEND, 8'h00, tk_field, 0, LS_OK);
        cnt = tk_too_many ? MAX_FIELDS : tk_field + 1;
        if (tk_in_quotes) st = LS_QUOTE;
        else if (tk_escape) st = LS_ESCAPE;
        else if (tk_too_many) st = LS_TOO_MANY;
        else if (tk_overflow) st = LS_OVERFLOW;
        else st = LS_OK;
        add_token(KIND_LEND, 8'h00, 0, cnt, st);
      end
      clear_line();
    end else begin
      if (tk_line_head) begin
        tk_line_head = 1'b0;
        if (ch == CH_CR) dropped = 1;
      end
      if (!dropped) begin
        if (ch != CH_CR && ch != CH_LF) tk_started = 1'b1;
        if (tk_too_many) begin
          if (tk_escape) tk_escape = 1'b0;
          else if (ch == CH_QUOTE) tk_in_quotes = !tk_in_quotes;
          else if (ch == CH_BSLASH) tk_escape = 1'b1;
        end else if (tk_escape) begin
          put_content(ch);
          tk_escape    = 1'b0;
          tk_skip_lead = 1'b0;
        end else if (ch == CH_QUOTE) begin
          tk_in_quotes = !tk_in_quotes;
        end else if (!tk_in_quotes && ch == delim) begin
          tk_started = 1'b1;
          add_token(KIND_FEND, 8'h00, tk_field, 0, LS_OK);
          blank_q.delete();
          tk_skip_lead = 1'b1;
          if (tk_field + 1 >= MAX_FIELDS) tk_too_many = 1'b1;
          else tk_field++;
        end else if (ch == CH_BSLASH) begin
          tk_escape = 1'b1;
        end else if (tk_skip_lead && (ch == CH_SPACE || ch == CH_TAB)) begin
        end else begin
          put_content(ch);
          tk_skip_lead = 1'b0;
        end
      end
    end
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    step_tokens.delete();
  endfunction

  // input side: bursts with random gaps
  always @(posedge clk) begin : drive_proc
    line_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize_word(in_command, in_char_byte);
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_command   <= w.cmd;
          in_char_byte <= w.ch;
          in_valid     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: compare and stall pattern
  always @(posedge clk) begin : watch_proc
    token_t e;
    logic   s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d byte %02h", out_kind,
                                    out_out_byte));
        end else begin
          e = expected_tokens.pop_front();
          if (out_kind !== e.kind || out_out_byte !== e.data ||
              out_field_index !== e.index || out_field_count !== e.count ||
              out_line_status !== e.status || out_last !== e.last)
            report_mismatch($sformatf(
              "got k%0d b%02h i%0d c%0d s%0d l%0d exp k%0d b%02h i%0d c%0d s%0d l%0d",
              out_kind, out_out_byte, out_field_index, out_field_count,
              out_line_status, out_last, e.kind, e.data, e.index, e.count,
              e.status, e.last));
        end
      end
      if (!hold_done && words_in >= HOLD_AFTER) begin
        hold_done = 1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        s = 1'b1;
      end else if (stall_mode == 1) begin
        s = $urandom_range(0, 1);
      end else if (stall_mode == 2) begin
        s = ($urandom_range(0, 3) != 0);
      end else begin
        s = 1'b0;
      end
      out_stall <= s;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // stimulus
  task automatic push_word(input logic cmd, input logic [7:0] ch);
    line_word_t w;
    w.cmd = cmd;
    w.ch  = ch;
    pending_words.push_back(w);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 45) return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    if (r < 50) return ($urandom_range(0, 1) == 0) ? CH_CR : CH_LF;
    if (r < 58) return CH_QUOTE;
    if (r < 65) return CH_BSLASH;
    if (r < 80) return delim;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_too_many_line();
    int nf;
    nf = $urandom_range(MAX_FIELDS + 1, MAX_FIELDS + 4);
    for (int i = 0; i < nf; i++) begin
      if ($urandom_range(0, 1) == 0) push_word(CMD_CHAR, 8'h61 + 8'(i % 26));
      push_word(CMD_CHAR, delim);
    end
    repeat ($urandom_range(0, 4)) push_word(CMD_CHAR, pick_char());
    push_word(CMD_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_overflow_line();
    int         nb;
    logic [7:0] b;
    push_word(CMD_CHAR, 8'h61 + 8'($urandom_range(0, 25)));
    nb = ($urandom_range(0, 1) == 0) ? PENDING_DEPTH : $urandom_range(PENDING_DEPTH - 2,
                                                                       PENDING_DEPTH + 8);
    for (int i = 0; i < nb; i++) begin
      case ($urandom_range(0, 3))
        0: b = CH_SPACE;
        1: b = CH_TAB;
        2: b = CH_CR;
        default: b = CH_LF;
      endcase
      if (b == delim) b = (delim == CH_SPACE) ? CH_LF : CH_SPACE;
      push_word(CMD_CHAR, b);
    end
    if ($urandom_range(0, 1) == 0) push_word(CMD_CHAR, 8'h7A);
    push_word(CMD_EOL, 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_random_line();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      queue_too_many_line();
    end else if (r == 1) begin
      queue_overflow_line();
    end else if (r == 2) begin
      repeat ($urandom_range(0, 2)) push_word(CMD_CHAR, ($urandom_range(0, 1) == 0) ?
                                                        CH_CR : CH_LF);
      push_word(CMD_EOL, 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 9) == 0) push_word(CMD_CHAR, CH_CR);
      repeat ($urandom_range(1, 14)) push_word(CMD_CHAR, pick_char());
      push_word(CMD_EOL, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_random_lines(input int target);
    int start;
    start = pending_words.size();
    while (pending_words.size() - start < target) queue_random_line();
  endtask

  task automatic write_delim(input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DELIM, 2'b00};
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    delim = value;
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= CMD_CHAR;
    in_char_byte <= 8'h00;
    out_stall    <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= 3'd0;
    pwdata       <= 32'h0;
    delim = CH_COMMA;
    clear_line();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // leading CR, skipped blanks, quoted delimiter, escapes, byte extremes
    push_word(CMD_CHAR, CH_CR);
    push_word(CMD_CHAR, CH_SPACE);
    push_word(CMD_CHAR, CH_TAB);
    push_word(CMD_CHAR, 8'h41);
    push_word(CMD_CHAR, CH_SPACE);
    push_word(CMD_CHAR, CH_QUOTE);
    push_word(CMD_CHAR, CH_COMMA);
    push_word(CMD_CHAR, CH_QUOTE);
    push_word(CMD_CHAR, CH_BSLASH);
    push_word(CMD_CHAR, CH_COMMA);
    push_word(CMD_CHAR, 8'h00);
    push_word(CMD_CHAR, 8'hFF);
    push_word(CMD_CHAR, CH_COMMA);
    push_word(CMD_CHAR, CH_BSLASH);
    push_word(CMD_CHAR, CH_SPACE);
    push_word(CMD_CHAR, 8'h62);
    push_word(CMD_CHAR, CH_LF);
    push_word(CMD_EOL, 8'hFF);
    push_word(CMD_EOL, 8'h00);
    push_word(CMD_CHAR, CH_QUOTE);
    push_word(CMD_CHAR, 8'h78);
    push_word(CMD_EOL, 8'hA5);
    push_word(CMD_CHAR, CH_BSLASH);
    push_word(CMD_EOL, 8'h5A);
    settle();

    write_delim(8'h3B);
    queue_too_many_line();
    queue_overflow_line();
    queue_random_lines(60);
    settle();

    write_delim(8'h00);
    queue_random_lines(8);
    settle();
    write_delim(8'hFF);
    queue_random_lines(8);
    settle();
    write_delim(CH_QUOTE);
    queue_random_lines(8);
    settle();
    write_delim(CH_TAB);
    queue_random_lines(8);
    settle();
    write_delim(8'($urandom_range(0, 255)));
    queue_random_lines(8);
    settle();

    if (expected_tokens.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_tokens.size()));
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
